>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dfe_pkg.sv
// Package with the shared types and constants of the delimited frame extractor.
`timescale 1ns / 1ps
package dfe_pkg;

  localparam int BYTE_W    = 8;
  localparam int MARKER_W  = 64;
  localparam int LENGTH_W  = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_START_LENGTH = 2'd1,
    CFG_END_MARKER   = 2'd2,
    CFG_END_LENGTH   = 2'd3
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_PUSH    = 1'b0,
    KIND_EXTRACT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_BYTE  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] unit_byte;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [MARKER_W-1:0] start_marker;
    logic [LENGTH_W-1:0] start_length;
    logic [MARKER_W-1:0] end_marker;
    logic [LENGTH_W-1:0] end_length;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN_RD,
    B_SCAN_CMP,
    B_DECIDE,
    B_EMIT_RD,
    B_EMIT_WR,
    B_FAIL,
    B_EMPTY
  } back_state_t;

endpackage

>>> hw/rtl/dfe_front.sv
// Front end: accepts items, drops zero pushes and queues commands for the back end.
`timescale 1ns / 1ps
module dfe_front
  import dfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  in_item_t    slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push_en;
  logic        keep;

  assign in_ready = (cnt_r != 2'd2);
  // A push of a zero byte changes nothing, so it is taken and discarded here.
  assign keep     = !(in_data.kind == KIND_PUSH && in_data.data_byte == '0);
  assign push_en  = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_en;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_valid);
    cnt_nxt    = cnt_r + {1'b0, push_en} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> hw/rtl/dfe_back.sv
// Back end: circular byte store, delimiter search, unit readout and result register.
`timescale 1ns / 1ps
module dfe_back
  import dfe_pkg::*;
#(
  parameter int BUFFER_BYTES = 64,
  parameter int MARKER_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int WW = ((CW > LENGTH_W) ? CW : LENGTH_W) + 1;

  logic [BYTE_W-1:0] mem [BUFFER_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  back_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] stop_r, stop_nxt;
  logic [CW-1:0] cut_r, cut_nxt;
  logic          s_found_r, s_found_nxt;
  logic          e_found_r, e_found_nxt;
  logic [MARKER_BYTES-1:0][BYTE_W-1:0] win_r, win_nxt, new_win;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic          slot_free;
  logic          s_present, e_present;
  logic          match_s, match_e;
  logic [WW-1:0] seen;

  // Physical address of a position counted from the oldest byte.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] rel);
    logic [AW:0] sum;
    begin
      sum = (AW+1)'(head) + (AW+1)'(rel);
      if (sum >= (AW+1)'(BUFFER_BYTES)) begin
        sum = sum - (AW+1)'(BUFFER_BYTES);
      end
      phys = sum[AW-1:0];
    end
  endfunction

  assign s_present = (cfg.start_length != '0) &&
                     (cfg.start_length <= LENGTH_W'(MARKER_BYTES));
  assign e_present = (cfg.end_length != '0) &&
                     (cfg.end_length <= LENGTH_W'(MARKER_BYTES));
  assign slot_free = !out_valid_r || out_ready;
  assign mem_raddr = phys(head_r, j_r);
  assign mem_waddr = phys(head_r, count_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign seen      = WW'(j_r) + WW'(1);

  // Window of the most recent bytes, newest at position zero.
  always_comb begin
    new_win[0] = rd_data_r;
    for (int k = 1; k < MARKER_BYTES; k++) begin
      new_win[k] = win_r[k-1];
    end
  end

  // A marker ends on the newest byte when byte i matches window position len-1-i.
  always_comb begin
    match_s = s_present && (seen >= WW'(cfg.start_length));
    match_e = e_present && (seen >= WW'(cfg.end_length));
    for (int i = 0; i < MARKER_BYTES; i++) begin
      for (int k = 0; k < MARKER_BYTES; k++) begin
        if ((LENGTH_W'(i) < cfg.start_length) &&
            (LENGTH_W'(k) == cfg.start_length - LENGTH_W'(1) - LENGTH_W'(i)) &&
            (new_win[k] != cfg.start_marker[i*BYTE_W +: BYTE_W])) begin
          match_s = 1'b0;
        end
        if ((LENGTH_W'(i) < cfg.end_length) &&
            (LENGTH_W'(k) == cfg.end_length - LENGTH_W'(1) - LENGTH_W'(i)) &&
            (new_win[k] != cfg.end_marker[i*BYTE_W +: BYTE_W])) begin
          match_e = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    j_nxt         = j_r;
    first_nxt     = first_r;
    stop_nxt      = stop_r;
    cut_nxt       = cut_r;
    s_found_nxt   = s_found_r;
    e_found_nxt   = e_found_r;
    win_nxt       = win_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    q_pop         = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_PUSH) begin
            mem_we = 1'b1;
            if (count_r == CW'(BUFFER_BYTES)) begin
              head_nxt = phys(head_r, CW'(1));
            end else begin
              count_nxt = count_r + CW'(1);
            end
          end else if (!s_present || !e_present || count_r == '0) begin
            state_nxt = B_FAIL;
          end else begin
            j_nxt       = '0;
            s_found_nxt = 1'b0;
            e_found_nxt = 1'b0;
            state_nxt   = B_SCAN_RD;
          end
        end
      end
      B_SCAN_RD: begin
        state_nxt = B_SCAN_CMP;
      end
      B_SCAN_CMP: begin
        win_nxt = new_win;
        if (!s_found_r && match_s) begin
          s_found_nxt = 1'b1;
          first_nxt   = CW'(seen);
        end
        if (match_e) begin
          // The first end marker settles the outcome; the scan stops here.
          e_found_nxt = 1'b1;
          stop_nxt    = CW'(seen - WW'(cfg.end_length));
          cut_nxt     = CW'(seen);
          state_nxt   = B_DECIDE;
        end else if (seen == WW'(count_r)) begin
          state_nxt = B_DECIDE;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = B_SCAN_RD;
        end
      end
      B_DECIDE: begin
        if (!s_found_r || !e_found_r || stop_r < first_r) begin
          state_nxt = B_FAIL;
        end else if (stop_r == first_r) begin
          state_nxt = B_EMPTY;
        end else begin
          j_nxt     = first_r;
          state_nxt = B_EMIT_RD;
        end
      end
      B_EMIT_RD: begin
        state_nxt = B_EMIT_WR;
      end
      B_EMIT_WR: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ST_BYTE;
          out_data_nxt.unit_byte = rd_data_r;
          out_data_nxt.last      = (j_r + CW'(1) == stop_r);
          if (j_r + CW'(1) == stop_r) begin
            head_nxt  = phys(head_r, cut_r);
            count_nxt = count_r - cut_r;
            state_nxt = B_IDLE;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = B_EMIT_RD;
          end
        end
      end
      B_FAIL: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ST_NONE;
          out_data_nxt.unit_byte = '0;
          out_data_nxt.last      = 1'b1;
          state_nxt              = B_IDLE;
        end
      end
      B_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ST_EMPTY;
          out_data_nxt.unit_byte = '0;
          out_data_nxt.last      = 1'b1;
          head_nxt               = phys(head_r, cut_r);
          count_nxt              = count_r - cut_r;
          state_nxt              = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    first_r    <= first_nxt;
    stop_r     <= stop_nxt;
    cut_r      <= cut_nxt;
    s_found_r  <= s_found_nxt;
    e_found_r  <= e_found_nxt;
    win_r      <= win_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= q_item.data_byte;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule

>>> hw/rtl/delimited_frame_extractor_core.sv
// Top level of the delimited frame extractor: configuration registers and the two ends.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_item_t (kind, data_byte)
//   out_     output     out_valid/out_ready out_item_t (status, unit_byte, last)
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// A push is stored by the back end in its idle state; a two-entry queue decouples input from it.
// An extraction scans the store byte by byte in a read and a compare state, up to the first end marker,
// then emits the unit byte by byte in a read and a write state, the write waiting on the output register.
// The scan and readout share the single read port of the byte store.
// Reset is synchronous and active low; it empties the store and the queue.
// A stalled result holds in the output register while the queue keeps taking items until it is full.
`timescale 1ns / 1ps
module delimited_frame_extractor_core
  import dfe_pkg::*;
#(
  parameter int BUFFER_BYTES = 64,
  parameter int MARKER_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MARKER_W-1:0]  cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_valid;
  in_item_t q_item;
  logic     q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_MARKER: cfg_r.start_marker <= cfg_wdata;
        CFG_START_LENGTH: cfg_r.start_length <= cfg_wdata[LENGTH_W-1:0];
        CFG_END_MARKER:   cfg_r.end_marker   <= cfg_wdata;
        CFG_END_LENGTH:   cfg_r.end_length   <= cfg_wdata[LENGTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  dfe_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MARKER_BYTES (MARKER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/dfe_checker.sv
// Port checker for the delimited frame extractor, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dfe_checker
  import dfe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled result changed")
  `ASSERT_IMPL(a_single_last, out_valid && out_data.status != ST_BYTE, out_data.last, "lone result without last")
  `ASSERT_IMPL(a_zero_byte, out_valid && out_data.status != ST_BYTE, out_data.unit_byte == '0, "unit byte set without data")

endmodule

bind delimited_frame_extractor_core dfe_checker u_dfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
